FILE: rtl/cdcacm_pkg.sv
package cdcacm_pkg;

	localparam int unsigned MAX_CONFIG_BYTES_DEF = 512;

	localparam logic [7:0] DESC_INTERFACE = 8'h04;
	localparam logic [7:0] DESC_ENDPOINT  = 8'h05;
	localparam logic [7:0] IF_MIN_LEN     = 8'd9;
	localparam logic [7:0] EP_MIN_LEN     = 8'd7;
	localparam logic [7:0] DESC_MIN_LEN   = 8'd2;

	localparam logic [7:0] CLASS_COMM     = 8'h02;
	localparam logic [7:0] SUBCLASS_ACM   = 8'h02;
	localparam logic [7:0] PROTOCOL_AT    = 8'h01;
	localparam logic [7:0] CLASS_DATA     = 8'h0A;

	localparam logic [1:0] XFER_BULK      = 2'b10;
	localparam int unsigned EP_DIR_BIT    = 7;
	localparam logic [15:0] MPS_DEFAULT   = 16'd64;
	localparam logic [7:0] NO_INTERFACE   = 8'hFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  comm_interface;
		logic [7:0]  in_endpoint;
		logic [15:0] in_max_packet;
		logic [7:0]  out_endpoint;
		logic [15:0] out_max_packet;
	} result_t;

	// One complete descriptor, reported in the cycle its final byte is taken.
	typedef struct packed {
		logic            done;
		logic [7:0]      kind;
		logic [7:0]      len;
		logic [5:0][7:0] cap;
	} desc_evt_t;

endpackage

FILE: rtl/usb_cdc_acm_descriptor_scanner.sv
// Scans a USB configuration descriptor set, one byte per transaction, for a CDC-ACM
// function. Bytes enter an input register and are processed from there, so a byte
// can be taken every clock unless the input stalls. One result transaction follows
// each byte marked last_byte. It carries the first ACM communications interface and
// the last bulk IN and bulk OUT endpoints of the first data interface at alternate
// setting 0. The result is loaded into the output register when that byte leaves the
// input register. The output register lets the next set stream in while a result
// waits; only a last_byte that finds the previous result still untaken stalls the input.
// After each result the scanner is clear for a new set. Bytes beyond MAX_CONFIG_BYTES
// in one set are ignored, but a last_byte mark on one of them still ends the set.
module usb_cdc_acm_descriptor_scanner #(
	parameter int unsigned MAX_CONFIG_BYTES = cdcacm_pkg::MAX_CONFIG_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  cdcacm_pkg::in_item_t byte_item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output cdcacm_pkg::result_t  result
);

	logic                  valid_s1;
	cdcacm_pkg::in_item_t  item_s1;
	logic                  advance;
	logic                  result_valid_q;
	cdcacm_pkg::result_t   result_q;
	cdcacm_pkg::result_t   result_nxt;
	cdcacm_pkg::desc_evt_t evt;

	// Only a last byte needs the output register to be free.
	assign advance    = valid_s1 && (!item_s1.last_byte || !result_valid_q || result_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	cdcacm_framer #(
		.MAX_CONFIG_BYTES(MAX_CONFIG_BYTES)
	) u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (item_s1.data_byte),
		.last_byte (item_s1.last_byte),
		.evt       (evt)
	);

	cdcacm_picker u_picker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.last_byte (item_s1.last_byte),
		.evt       (evt),
		.result    (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			result_q <= result_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_found_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.found |->
		(result.comm_interface != cdcacm_pkg::NO_INTERFACE) &&
		(result.in_endpoint != 8'd0) && (result.out_endpoint != 8'd0))
		else $error("found set without all three picks");

	a_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.in_endpoint == 8'd0) == (result.in_max_packet == 16'd0)))
		else $error("bulk IN address and packet size disagree");

	a_dir_bits: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !result.out_endpoint[cdcacm_pkg::EP_DIR_BIT] &&
		((result.in_endpoint == 8'd0) || result.in_endpoint[cdcacm_pkg::EP_DIR_BIT]))
		else $error("endpoint pick has the wrong direction");

endmodule

FILE: rtl/cdcacm_framer.sv
module cdcacm_framer #(
	parameter int unsigned MAX_CONFIG_BYTES = cdcacm_pkg::MAX_CONFIG_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output cdcacm_pkg::desc_evt_t evt
);

	localparam int unsigned CNT_W = $clog2(MAX_CONFIG_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CONFIG_BYTES);

	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic [7:0]       idx_q, idx_nxt;
	logic [7:0]       len_q, len_nxt;
	logic [7:0]       kind_q, kind_nxt;
	logic             stopped_q, stopped_nxt;
	logic [5:0][7:0]  cap_q, cap_nxt;
	logic             in_bound;
	logic             take;
	logic             at_end;

	assign in_bound = cnt_q < CNT_MAX;
	assign take     = step && in_bound && !stopped_q;
	assign at_end   = ({1'b0, idx_q} + 9'd1) == {1'b0, len_q};

	always_comb begin
		cnt_nxt     = cnt_q;
		idx_nxt     = idx_q;
		len_nxt     = len_q;
		kind_nxt    = kind_q;
		stopped_nxt = stopped_q;
		cap_nxt     = cap_q;
		if (step && in_bound) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end
		if (take) begin
			if (idx_q == 8'd0) begin
				if (data_byte < cdcacm_pkg::DESC_MIN_LEN) begin
					stopped_nxt = 1'b1;
				end else begin
					len_nxt = data_byte;
					cap_nxt = '0;
					idx_nxt = 8'd1;
				end
			end else begin
				if (idx_q == 8'd1) begin
					kind_nxt = data_byte;
				end else if (idx_q <= 8'd7) begin
					cap_nxt[3'(idx_q - 8'd2)] = data_byte;
				end
				idx_nxt = at_end ? 8'd0 : idx_q + 8'd1;
			end
		end
	end

	always_comb begin
		evt.done = take && (idx_q != 8'd0) && at_end;
		evt.kind = kind_nxt;
		evt.len  = len_q;
		evt.cap  = cap_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			idx_q     <= '0;
			len_q     <= '0;
			kind_q    <= '0;
			stopped_q <= 1'b0;
			cap_q     <= '0;
		end else if (step && last_byte) begin
			// The set is finished: start clean for the next one.
			cnt_q     <= '0;
			idx_q     <= '0;
			len_q     <= '0;
			kind_q    <= '0;
			stopped_q <= 1'b0;
			cap_q     <= '0;
		end else if (step) begin
			cnt_q     <= cnt_nxt;
			idx_q     <= idx_nxt;
			len_q     <= len_nxt;
			kind_q    <= kind_nxt;
			stopped_q <= stopped_nxt;
			cap_q     <= cap_nxt;
		end
	end

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("byte counter ran past the size bound");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && !(step && last_byte) |=> stopped_q)
		else $error("scan restarted before the end of the set");

endmodule

FILE: rtl/cdcacm_picker.sv
module cdcacm_picker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  last_byte,
	input  cdcacm_pkg::desc_evt_t evt,
	output cdcacm_pkg::result_t   result
);

	logic [7:0]  cur_if_q, cur_if_nxt;
	logic [7:0]  cur_alt_q, cur_alt_nxt;
	logic [7:0]  cur_class_q, cur_class_nxt;
	logic [7:0]  cur_sub_q, cur_sub_nxt;
	logic [7:0]  cur_proto_q, cur_proto_nxt;
	logic [7:0]  comm_q, comm_nxt;
	logic [7:0]  data_if_q, data_if_nxt;
	logic [7:0]  in_addr_q, in_addr_nxt;
	logic [15:0] in_mps_q, in_mps_nxt;
	logic [7:0]  out_addr_q, out_addr_nxt;
	logic [15:0] out_mps_q, out_mps_nxt;
	logic [15:0] ep_mps;
	logic        is_if;
	logic        is_ep;

	assign is_if = evt.done && (evt.kind == cdcacm_pkg::DESC_INTERFACE) &&
		(evt.len >= cdcacm_pkg::IF_MIN_LEN);
	assign is_ep = evt.done && (evt.kind == cdcacm_pkg::DESC_ENDPOINT) &&
		(evt.len >= cdcacm_pkg::EP_MIN_LEN) &&
		(cur_if_q != cdcacm_pkg::NO_INTERFACE) && (cur_alt_q == 8'd0) &&
		(cur_if_q == data_if_q) && (cur_class_q == cdcacm_pkg::CLASS_DATA);
	assign ep_mps = ({evt.cap[3], evt.cap[2]} == 16'd0) ? cdcacm_pkg::MPS_DEFAULT :
		{evt.cap[3], evt.cap[2]};

	always_comb begin
		cur_if_nxt    = cur_if_q;
		cur_alt_nxt   = cur_alt_q;
		cur_class_nxt = cur_class_q;
		cur_sub_nxt   = cur_sub_q;
		cur_proto_nxt = cur_proto_q;
		comm_nxt      = comm_q;
		data_if_nxt   = data_if_q;
		in_addr_nxt   = in_addr_q;
		in_mps_nxt    = in_mps_q;
		out_addr_nxt  = out_addr_q;
		out_mps_nxt   = out_mps_q;
		if (is_if) begin
			cur_if_nxt    = evt.cap[0];
			cur_alt_nxt   = evt.cap[1];
			cur_class_nxt = evt.cap[3];
			cur_sub_nxt   = evt.cap[4];
			cur_proto_nxt = evt.cap[5];
			if ((evt.cap[3] == cdcacm_pkg::CLASS_COMM) &&
				(evt.cap[4] == cdcacm_pkg::SUBCLASS_ACM) &&
				(evt.cap[5] == cdcacm_pkg::PROTOCOL_AT) &&
				(comm_q == cdcacm_pkg::NO_INTERFACE)) begin
				comm_nxt = evt.cap[0];
			end
			if ((evt.cap[3] == cdcacm_pkg::CLASS_DATA) &&
				(data_if_q == cdcacm_pkg::NO_INTERFACE)) begin
				data_if_nxt = evt.cap[0];
			end
		end else if (is_ep && (evt.cap[1][1:0] == cdcacm_pkg::XFER_BULK)) begin
			if (evt.cap[0][cdcacm_pkg::EP_DIR_BIT]) begin
				in_addr_nxt = evt.cap[0];
				in_mps_nxt  = ep_mps;
			end else begin
				out_addr_nxt = evt.cap[0];
				out_mps_nxt  = ep_mps;
			end
		end
	end

	always_comb begin
		result.found = (comm_nxt != cdcacm_pkg::NO_INTERFACE) &&
			(in_addr_nxt != 8'd0) && (out_addr_nxt != 8'd0);
		result.comm_interface = comm_nxt;
		result.in_endpoint    = in_addr_nxt;
		result.in_max_packet  = in_mps_nxt;
		result.out_endpoint   = out_addr_nxt;
		result.out_max_packet = out_mps_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_if_q    <= cdcacm_pkg::NO_INTERFACE;
			cur_alt_q   <= '0;
			cur_class_q <= '0;
			cur_sub_q   <= '0;
			cur_proto_q <= '0;
			comm_q      <= cdcacm_pkg::NO_INTERFACE;
			data_if_q   <= cdcacm_pkg::NO_INTERFACE;
			in_addr_q   <= '0;
			in_mps_q    <= '0;
			out_addr_q  <= '0;
			out_mps_q   <= '0;
		end else if (step && last_byte) begin
			cur_if_q    <= cdcacm_pkg::NO_INTERFACE;
			cur_alt_q   <= '0;
			cur_class_q <= '0;
			cur_sub_q   <= '0;
			cur_proto_q <= '0;
			comm_q      <= cdcacm_pkg::NO_INTERFACE;
			data_if_q   <= cdcacm_pkg::NO_INTERFACE;
			in_addr_q   <= '0;
			in_mps_q    <= '0;
			out_addr_q  <= '0;
			out_mps_q   <= '0;
		end else if (step) begin
			cur_if_q    <= cur_if_nxt;
			cur_alt_q   <= cur_alt_nxt;
			cur_class_q <= cur_class_nxt;
			cur_sub_q   <= cur_sub_nxt;
			cur_proto_q <= cur_proto_nxt;
			comm_q      <= comm_nxt;
			data_if_q   <= data_if_nxt;
			in_addr_q   <= in_addr_nxt;
			in_mps_q    <= in_mps_nxt;
			out_addr_q  <= out_addr_nxt;
			out_mps_q   <= out_mps_nxt;
		end
	end

	a_data_if_once: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_byte && (data_if_q != cdcacm_pkg::NO_INTERFACE) |=>
		$stable(data_if_q))
		else $error("data interface changed after it was chosen");

endmodule
